@@ design/bfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types and constants of the bit/frame error counter.
// ----------------------------------------------------------------------------
package bfe_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERROR_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_LIMIT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_FRAME   = 2'd2;

  localparam logic [15:0] MAX_ERROR_FRAMES_RST = 16'd200;
  localparam logic        AUTO_LIMIT_RST       = 1'b1;
  localparam logic [15:0] BITS_PER_FRAME_RST   = 16'd1;

  // ber test: bit total split at this bit; anything above can never pass
  localparam int BE_LO_W = 29;
  localparam int PROD_W  = 60;
  localparam int RATE_W  = 48;

  localparam logic [PROD_W-1:0] DEC_1E6 = 60'd1000000;
  localparam logic [PROD_W-1:0] DEC_10  = 60'd10;
  localparam logic [PROD_W-1:0] DEC_100 = 60'd100;
  localparam logic [PROD_W-1:0] DEC_1E3 = 60'd1000;

  typedef struct packed {
    logic [7:0] error_byte;
    logic       last_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [15:0] frame_bit_errors;
    logic        frame_in_error;
    logic [47:0] total_bit_errors;
    logic [31:0] total_frame_errors;
    logic [31:0] total_frames;
    logic [15:0] error_frame_limit;
    logic        limit_reached;
  } result_t;

  // totals of one finished frame, handed to the limit pipeline
  typedef struct packed {
    logic [15:0]        frame_bit_errors;
    logic               frame_in_error;
    logic [47:0]        total_bit_errors;
    logic [31:0]        total_frame_errors;
    logic [31:0]        total_frames;
    logic [BE_LO_W-1:0] be_lo;
    logic               be_big;
  } snap_t;

endpackage

@@ design/bfe_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfe_stream_if
// Valid/ready stream channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface bfe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/bfe_limit_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfe_limit_pipe
// Pipelined BER test and frame-error limit selection on frame snapshots.
// ----------------------------------------------------------------------------
module bfe_limit_pipe import bfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        snap_valid_i,
  output logic        snap_ready_o,
  input  snap_t       snap_i,
  input  logic [15:0] max_err_i,
  input  logic        auto_i,
  input  logic [15:0] bits_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);

  typedef struct packed {
    logic [15:0] frame_bit_errors;
    logic        frame_in_error;
    logic [47:0] total_bit_errors;
    logic [31:0] total_frame_errors;
    logic [31:0] total_frames;
  } pay_t;

  pay_t               pay1_q, pay2_q, pay3_q, pay4_q;
  logic [BE_LO_W-1:0] be_lo1_q;
  logic               big1_q, big2_q, big3_q;
  logic [RATE_W-1:0]  rate2_q, rate3_q;
  logic [PROD_W-1:0]  p6_2_q;
  logic [PROD_W-1:0]  p6_3_q, p7_3_q, p8_3_q, p9_3_q;
  logic [3:0]         below4_q;   // [0] 1e-6 ... [3] 1e-9
  result_t            res_q;

  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;

  logic [PROD_W-1:0] rate_ext;
  logic [15:0]       limit;

  assign rdy_o = !vo_q || res_ready_i;
  assign rdy4  = !v4_q || rdy_o;
  assign rdy3  = !v3_q || rdy4;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign snap_ready_o = rdy1;

  assign rate_ext = PROD_W'(rate3_q);

  always_comb begin
    priority if (!auto_i)   limit = max_err_i;
    else if (below4_q[3])   limit = max_err_i >> 4;
    else if (below4_q[2])   limit = max_err_i >> 3;
    else if (below4_q[1])   limit = max_err_i >> 2;
    else if (below4_q[0])   limit = max_err_i >> 1;
    else                    limit = max_err_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1)  v1_q <= snap_valid_i;
      if (rdy2)  v2_q <= v1_q;
      if (rdy3)  v3_q <= v2_q;
      if (rdy4)  v4_q <= v3_q;
      if (rdy_o) vo_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // capture snapshot
    if (rdy1 && snap_valid_i) begin
      pay1_q   <= '{snap_i.frame_bit_errors, snap_i.frame_in_error, snap_i.total_bit_errors,
                    snap_i.total_frame_errors, snap_i.total_frames};
      be_lo1_q <= snap_i.be_lo;
      big1_q   <= snap_i.be_big;
    end
    // frame total times bits per frame, bit errors times 1e6
    if (rdy2 && v1_q) begin
      pay2_q  <= pay1_q;
      big2_q  <= big1_q;
      rate2_q <= RATE_W'(pay1_q.total_frames) * RATE_W'(bits_i);
      p6_2_q  <= PROD_W'(be_lo1_q) * DEC_1E6;
    end
    // decade scaling by small constants
    if (rdy3 && v2_q) begin
      pay3_q  <= pay2_q;
      big3_q  <= big2_q;
      rate3_q <= rate2_q;
      p6_3_q  <= p6_2_q;
      p7_3_q  <= p6_2_q * DEC_10;
      p8_3_q  <= p6_2_q * DEC_100;
      p9_3_q  <= p6_2_q * DEC_1E3;
    end
    // threshold compares
    if (rdy4 && v3_q) begin
      pay4_q      <= pay3_q;
      below4_q[0] <= !big3_q && (p6_3_q < rate_ext);
      below4_q[1] <= !big3_q && (p7_3_q < rate_ext);
      below4_q[2] <= !big3_q && (p8_3_q < rate_ext);
      below4_q[3] <= !big3_q && (p9_3_q < rate_ext);
    end
    // limit and result
    if (rdy_o && v4_q) begin
      res_q.frame_bit_errors   <= pay4_q.frame_bit_errors;
      res_q.frame_in_error     <= pay4_q.frame_in_error;
      res_q.total_bit_errors   <= pay4_q.total_bit_errors;
      res_q.total_frame_errors <= pay4_q.total_frame_errors;
      res_q.total_frames       <= pay4_q.total_frames;
      res_q.error_frame_limit  <= limit;
      res_q.limit_reached      <= pay4_q.total_frame_errors >= 32'(limit);
    end
  end

  assign res_valid_o = vo_q;
  assign res_o       = res_q;

endmodule

@@ design/ber_fer_error_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_fer_error_counter
// Bit/frame error counter with a BER-scaled frame-error stop limit.
// ----------------------------------------------------------------------------
// results pass capture, product, scaling, compare and result registers
// throughput: 1 item per cycle from counters and pipeline unless out_o stalls
// reset: counters and pipeline cleared, registers to 200 / auto / 1 bit
// ----------------------------------------------------------------------------
module ber_fer_error_counter import bfe_pkg::*; #(
  parameter int BIT_COUNT_WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bfe_stream_if.sink            in_i,
  bfe_stream_if.source          out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int BW = BIT_COUNT_WIDTH;

  // configuration registers
  logic [15:0] max_err_q;
  logic        auto_q;
  logic [15:0] bits_q;

  // running counters
  logic [15:0]   run_q, run_d;
  logic [BW-1:0] bet_q, bet_d;
  logic [31:0]   fet_q, fet_d;
  logic [31:0]   ft_q,  ft_d;

  logic          accept, last;
  logic [15:0]   fe;
  logic          in_err;
  logic [BW:0]   bet_sum;
  logic [32:0]   fet_sum, ft_sum;
  logic [63:0]   be_ext;
  snap_t         snap;
  logic          snap_ready;

  assign accept = in_i.valid && snap_ready;
  assign last   = in_i.data.last_of_frame;
  assign in_i.ready = snap_ready;

  // frame error count including this item, held at all ones when full
  assign fe = ((in_i.data.error_byte != 8'd0) && (run_q != 16'hFFFF)) ? run_q + 16'd1 : run_q;
  assign in_err = (fe != 16'd0);

  // saturating totals
  assign bet_sum = {1'b0, bet_q} + (BW + 1)'(fe);
  assign fet_sum = {1'b0, fet_q} + 33'(in_err);
  assign ft_sum  = {1'b0, ft_q} + 33'd1;

  always_comb begin
    run_d = last ? 16'd0 : fe;
    bet_d = bet_sum[BW]  ? '1 : bet_sum[BW-1:0];
    fet_d = fet_sum[32]  ? '1 : fet_sum[31:0];
    ft_d  = ft_sum[32]   ? '1 : ft_sum[31:0];
  end

  // a bit total with anything above the split can never pass the weakest test
  assign be_ext = 64'(bet_d);

  always_comb begin
    snap.frame_bit_errors   = fe;
    snap.frame_in_error     = in_err;
    snap.total_bit_errors   = be_ext[47:0];
    snap.total_frame_errors = fet_d;
    snap.total_frames       = ft_d;
    snap.be_lo              = be_ext[BE_LO_W-1:0];
    snap.be_big             = |be_ext[63:BE_LO_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      bet_q <= '0;
      fet_q <= '0;
      ft_q  <= '0;
    end else if (accept) begin
      run_q <= run_d;
      if (last) begin
        bet_q <= bet_d;
        fet_q <= fet_d;
        ft_q  <= ft_d;
      end
    end
  end

  // register writes, out-of-range index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_err_q <= MAX_ERROR_FRAMES_RST;
      auto_q    <= AUTO_LIMIT_RST;
      bits_q    <= BITS_PER_FRAME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_ERROR_FRAMES: max_err_q <= cfg_data_i;
        CFG_AUTO_LIMIT:       auto_q    <= cfg_data_i[0];
        CFG_BITS_PER_FRAME:   bits_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // only finished frames enter the limit pipeline; other items just count
  bfe_limit_pipe u_limit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (in_i.valid && last),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .max_err_i    (max_err_q),
    .auto_i       (auto_q),
    .bits_i       (bits_q),
    .res_valid_o  (out_o.valid),
    .res_ready_i  (out_o.ready),
    .res_o        (out_o.data)
  );

endmodule
